@@ hw/rtl/session_packet_filter_seq_window_core_defines.svh @@
// Assertion macros shared by the checker of the session packet filter.
// Needs a signal named clock and a signal named reset in the scope of use.
`ifndef SESSION_PACKET_FILTER_SEQ_WINDOW_CORE_DEFINES_SVH
`define SESSION_PACKET_FILTER_SEQ_WINDOW_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPFSW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPFSW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/spfsw_pkg.sv @@
// Shared types and constants of the session packet filter.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package spfsw_pkg;

   localparam int NumCommands = 256;
   localparam int SeqIdxW = $clog2(NumCommands);
   localparam logic [8:0] CmdLimit = 9'(NumCommands);

   // Configuration register indexes.
   localparam int CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] CsrSecret    = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrAuthDone  = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrConnId    = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrProtoCmd  = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrAuthSub   = 3'd4;

   // Action codes.
   localparam logic [2:0] ActDrop    = 3'd0;
   localparam logic [2:0] ActReply   = 3'd1;
   localparam logic [2:0] ActUdp     = 3'd2;
   localparam logic [2:0] ActReady   = 3'd3;
   localparam logic [2:0] ActDisc    = 3'd4;
   localparam logic [2:0] ActAuthPkt = 3'd5;
   localparam logic [2:0] ActTcp     = 3'd6;

   typedef struct packed {
      logic        cmd;
      logic [15:0] total_len;
      logic [31:0] src_addr;
      logic [15:0] src_port;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
   } item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  client_id;
      logic [7:0]  command;
      logic [31:0] reply_addr;
      logic [15:0] reply_port;
   } result_type;

   typedef struct packed {
      logic [7:0] secret_code;
      logic       auth_done;
      logic [7:0] connection_id;
      logic [7:0] proto_cmd_code;
      logic [7:0] auth_subcmd_code;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [SeqIdxW-1:0] addr;
      logic [7:0]         data;
   } tbl_wr_type;

endpackage

@@ hw/rtl/spfsw_req_if.sv @@
// Input channel of the session packet filter: valid, ready and one header item.
// No dependencies.
`timescale 1ns / 1ps

interface spfsw_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] total_len;
   logic [31:0] src_addr;
   logic [15:0] src_port;
   logic [7:0]  byte0;
   logic [7:0]  byte1;
   logic [7:0]  byte2;
   logic [7:0]  byte3;

   modport source (output valid, cmd, total_len, src_addr, src_port,
                   byte0, byte1, byte2, byte3, input ready);
   modport sink (input valid, cmd, total_len, src_addr, src_port,
                 byte0, byte1, byte2, byte3, output ready);
endinterface

@@ hw/rtl/spfsw_rsp_if.sv @@
// Result channel of the session packet filter: valid, ready and one result item.
// No dependencies.
`timescale 1ns / 1ps

interface spfsw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  client_id;
   logic [7:0]  command;
   logic [31:0] reply_addr;
   logic [15:0] reply_port;

   modport source (output valid, action, client_id, command, reply_addr,
                   reply_port, input ready);
   modport sink (input valid, action, client_id, command, reply_addr,
                 reply_port, output ready);
endinterface

@@ hw/rtl/spfsw_csr.sv @@
// Configuration registers of the session packet filter.
// Depends on spfsw_pkg.
`timescale 1ns / 1ps

module spfsw_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [spfsw_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [7:0]                      csr_wr_data,
   output spfsw_pkg::cfg_type              cfg
);

   spfsw_pkg::cfg_type cfg_ff;
   spfsw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            spfsw_pkg::CsrSecret:   cfg_in.secret_code      = csr_wr_data;
            spfsw_pkg::CsrAuthDone: cfg_in.auth_done        = csr_wr_data[0];
            spfsw_pkg::CsrConnId:   cfg_in.connection_id    = csr_wr_data;
            spfsw_pkg::CsrProtoCmd: cfg_in.proto_cmd_code   = csr_wr_data;
            spfsw_pkg::CsrAuthSub:  cfg_in.auth_subcmd_code = csr_wr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.secret_code      <= 8'd0;
         cfg_ff.auth_done        <= 1'b0;
         cfg_ff.connection_id    <= 8'd0;
         cfg_ff.proto_cmd_code   <= 8'd255;
         cfg_ff.auth_subcmd_code <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/spfsw_seq_table.sv @@
// Per-command last sequence time table: one synchronous memory with a
// registered read, valid bits for reset, and a bypass of a same-edge write.
// Depends on spfsw_pkg.
`timescale 1ns / 1ps

module spfsw_seq_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [spfsw_pkg::SeqIdxW-1:0]   rd_addr,
   input  spfsw_pkg::tbl_wr_type           wr,
   output logic [7:0]                      rd_value
);

   logic [7:0]                      mem_ff [spfsw_pkg::NumCommands];
   logic [spfsw_pkg::NumCommands-1:0] vld_ff;
   logic [7:0]                      rd_data_ff;
   logic                            rd_vld_ff;
   logic                            fwd_hit_ff;
   logic [7:0]                      fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         fwd_data_ff <= wr.data;
      end
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff  <= vld_ff[rd_addr];
            fwd_hit_ff <= wr.en && (wr.addr == rd_addr);
         end
      end
   end

   assign rd_value = fwd_hit_ff ? fwd_data_ff : (rd_vld_ff ? rd_data_ff : 8'd0);

endmodule

@@ hw/rtl/spfsw_judge.sv @@
// Decision logic and connection state of the session packet filter.
// Depends on spfsw_pkg; the table entry arrives from spfsw_seq_table.
`timescale 1ns / 1ps

module spfsw_judge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  spfsw_pkg::item_type      item,
   input  logic [7:0]               last_time,
   input  spfsw_pkg::cfg_type       cfg,
   output spfsw_pkg::result_type    result,
   output spfsw_pkg::tbl_wr_type    tbl_wr
);

   typedef enum logic [1:0] {
      ST_WAIT  = 2'd0,
      ST_READY = 2'd1,
      ST_DISC  = 2'd2
   } conn_state_type;

   conn_state_type conn_state_ff, conn_state_in;
   logic [31:0]    bound_addr_ff, bound_addr_in;
   logic [15:0]    bound_port_ff, bound_port_in;

   logic       addr_match;
   logic       window_ok;
   logic [8:0] diff_up;
   logic [8:0] diff_down;

   assign addr_match = (item.src_addr == bound_addr_ff) && (item.src_port == bound_port_ff);
   assign diff_up    = {1'b0, item.byte3} - {1'b0, last_time};
   assign diff_down  = {1'b0, last_time} - {1'b0, item.byte3};

   // Serial-number window: ahead by 1 to 127, behind by more than 128, or either value zero.
   always_comb begin
      window_ok = 1'b0;
      if (item.byte3 == 8'd0 || last_time == 8'd0) begin
         window_ok = 1'b1;
      end else if (item.byte3 > last_time && diff_up < 9'd128) begin
         window_ok = 1'b1;
      end else if (item.byte3 < last_time && diff_down > 9'd128) begin
         window_ok = 1'b1;
      end
   end

   always_comb begin
      result         = '0;
      result.action  = spfsw_pkg::ActDrop;
      tbl_wr.en      = 1'b0;
      tbl_wr.addr    = item.byte2[spfsw_pkg::SeqIdxW-1:0];
      tbl_wr.data    = item.byte3;
      conn_state_in  = conn_state_ff;
      bound_addr_in  = bound_addr_ff;
      bound_port_in  = bound_port_ff;
      if (!item.cmd) begin
         if (item.total_len >= 16'd4 && item.byte1 == cfg.secret_code) begin
            if (conn_state_ff == ST_WAIT) begin
               bound_addr_in     = item.src_addr;
               bound_port_in     = item.src_port;
               result.action     = spfsw_pkg::ActReply;
               result.reply_addr = item.src_addr;
               result.reply_port = item.src_port;
            end else if (addr_match && item.byte2 != cfg.proto_cmd_code
                         && cfg.auth_done && item.total_len >= 16'd5
                         && {1'b0, item.byte2} < spfsw_pkg::CmdLimit && window_ok) begin
               tbl_wr.en        = (item.byte3 != 8'd0);
               result.action    = spfsw_pkg::ActUdp;
               result.client_id = item.byte0;
               result.command   = item.byte2;
            end
         end
      end else if (item.total_len >= 16'd2) begin
         if (item.byte0 == cfg.proto_cmd_code) begin
            if (item.byte1 == cfg.auth_subcmd_code && cfg.auth_done
                && conn_state_ff == ST_WAIT && item.total_len >= 16'd8) begin
               result.client_id = cfg.connection_id;
               if (addr_match) begin
                  conn_state_in = ST_READY;
                  result.action = spfsw_pkg::ActReady;
               end else begin
                  conn_state_in = ST_DISC;
                  result.action = spfsw_pkg::ActDisc;
               end
            end
         end else if (item.total_len >= 16'd3) begin
            result.action    = cfg.auth_done ? spfsw_pkg::ActTcp : spfsw_pkg::ActAuthPkt;
            result.client_id = cfg.connection_id;
            result.command   = item.byte0;
         end
      end
      if (!fire) begin
         tbl_wr.en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_state_ff <= ST_WAIT;
         bound_addr_ff <= 32'd0;
         bound_port_ff <= 16'd0;
      end else if (fire) begin
         conn_state_ff <= conn_state_in;
         bound_addr_ff <= bound_addr_in;
         bound_port_ff <= bound_port_in;
      end
   end

endmodule

@@ hw/rtl/session_packet_filter_seq_window_core.sv @@
// Session packet filter with a per-command serial-number sequence window.
// Depends on spfsw_pkg, spfsw_req_if, spfsw_rsp_if, spfsw_csr, spfsw_seq_table
// and spfsw_judge.
//
// Each packet header taken on req_ch (valid/ready) gives exactly one result
// on rsp_ch: an action code with client id, command and the bound address
// and port for an address reply. An accepted item is registered in the decision
// stage and then in the result register, which drives rsp_ch. One item is taken
// every cycle while rsp_ch does not stall.
// The rate is set by the sequence-time memory: it is read in the cycle an
// item is accepted and written back when the item leaves the decision
// stage; a write that hits the entry being read at the same edge is bypassed.
// If rsp_ch stalls, the result register and the decision stage each hold one
// item, then req_ch.ready drops until the result is taken.
// Reset (synchronous, active high) returns the connection to wait-for-auth,
// clears the bound address and port, loads the register defaults and marks
// every table entry as zero through valid bits, so no clearing pass is needed.
// csr_wr_en/csr_index/csr_wr_data write a register; the user must write only while
// the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module session_packet_filter_seq_window_core (
   input  logic                            clock,
   input  logic                            reset,
   spfsw_req_if.sink                       req_ch,
   spfsw_rsp_if.source                     rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [spfsw_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [7:0]                      csr_wr_data
);

   spfsw_pkg::cfg_type    cfg;
   spfsw_pkg::item_type   req_item;
   spfsw_pkg::item_type   s1_item_ff;
   logic                  s1_valid_ff, s1_valid_in;
   spfsw_pkg::result_type rsp_data_ff;
   spfsw_pkg::result_type judge_result;
   logic                  rsp_valid_ff, rsp_valid_in;
   spfsw_pkg::tbl_wr_type tbl_wr;
   logic [7:0]            last_time;
   logic                  req_fire;
   logic                  s1_adv;

   assign req_item = '{cmd: req_ch.cmd, total_len: req_ch.total_len,
                       src_addr: req_ch.src_addr, src_port: req_ch.src_port,
                       byte0: req_ch.byte0, byte1: req_ch.byte1,
                       byte2: req_ch.byte2, byte3: req_ch.byte3};

   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ch.ready);

   spfsw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   spfsw_seq_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (req_ch.byte2[spfsw_pkg::SeqIdxW-1:0]),
      .wr       (tbl_wr),
      .rd_value (last_time)
   );

   spfsw_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_adv),
      .item      (s1_item_ff),
      .last_time (last_time),
      .cfg       (cfg),
      .result    (judge_result),
      .tbl_wr    (tbl_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (s1_adv) begin
         rsp_data_ff <= judge_result;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.action     = rsp_data_ff.action;
   assign rsp_ch.client_id  = rsp_data_ff.client_id;
   assign rsp_ch.command    = rsp_data_ff.command;
   assign rsp_ch.reply_addr = rsp_data_ff.reply_addr;
   assign rsp_ch.reply_port = rsp_data_ff.reply_port;

endmodule

@@ hw/rtl/spfsw_checker.sv @@
// Port-level checks of the session packet filter, bound to the top level.
// Depends on spfsw_pkg and session_packet_filter_seq_window_core_defines.svh.
`timescale 1ns / 1ps
`include "session_packet_filter_seq_window_core_defines.svh"

module spfsw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  action,
   input logic [7:0]  client_id,
   input logic [7:0]  command,
   input logic [31:0] reply_addr,
   input logic [15:0] reply_port
);

   `SPFSW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(action) && $stable(client_id) && $stable(command) && $stable(reply_addr) && $stable(reply_port), "result item changed while stalled")
   `SPFSW_ASSERT_NOW(a_idle_after_reset, $past(reset), !rsp_valid, "result valid right after reset")
   `SPFSW_ASSERT_NOW(a_drop_zero, rsp_valid && action == spfsw_pkg::ActDrop, client_id == 8'd0 && command == 8'd0 && reply_addr == 32'd0 && reply_port == 16'd0, "drop item carries nonzero fields")
   `SPFSW_ASSERT_NOW(a_reply_ids_zero, rsp_valid && action == spfsw_pkg::ActReply, client_id == 8'd0 && command == 8'd0, "address reply carries an id or command")

endmodule

bind session_packet_filter_seq_window_core spfsw_checker u_spfsw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .action     (rsp_ch.action),
   .client_id  (rsp_ch.client_id),
   .command    (rsp_ch.command),
   .reply_addr (rsp_ch.reply_addr),
   .reply_port (rsp_ch.reply_port)
);
